// ----- sv/qmi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qmi_pkg;

    // Request codes carried on s_tuser.
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    // Result status codes carried on m_tuser.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Commands from the controller to the datapath. The first group acts at
    // the accepting edge, the fin_ group at the edge that completes a request.
    typedef struct packed {
        logic front_wr;       // write the request value at the front-half tail
        logic back_wr_tail;   // write the request value at the back-half tail
        logic back_wr_head;   // write the request value ahead of the back-half head
        logic front_rd;       // read and drop the front-half head
        logic back_rd;        // read and drop the back-half head (rebalancing move)
        logic fin_move;       // write the moved entry at the saved front-half slot
        logic fin_load;       // load the result data register
        logic fin_pop;        // result data comes from the front-half read
    } qmi_cmd_t;

    // Occupancy flags from the datapath.
    typedef struct packed {
        logic empty;
        logic full;
        logic odd;
    } qmi_status_t;

endpackage

`default_nettype wire

// ----- sv/qmi_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module qmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/qmi_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qmi_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [1:0]          s_opcode,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [1:0]               m_status,
    input  wire qmi_pkg::qmi_status_t status,
    output qmi_pkg::qmi_cmd_t        cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FIN  = 1'b1;

    logic       state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic [1:0] mstat_reg;
    logic       res_reg, res_next;
    logic [1:0] rstat_reg, rstat_next;
    logic       pop_reg, pop_next;
    logic       move_reg, move_next;
    logic       accept;
    logic       fin_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_status = mstat_reg;

    // A finishing request waits only if it has a result and the output is held.
    assign fin_go = (state_reg == ST_FIN) && (!res_reg || !mvalid_reg || m_tready);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        res_next   = res_reg;
        rstat_next = rstat_reg;
        pop_next   = pop_reg;
        move_next  = move_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_FIN;
                    res_next   = 1'b0;
                    rstat_next = qmi_pkg::STAT_OK;
                    pop_next   = 1'b0;
                    move_next  = 1'b0;
                    unique case (s_opcode)
                        qmi_pkg::OP_PUSH: begin
                            if (status.full) begin
                                res_next   = 1'b1;
                                rstat_next = qmi_pkg::STAT_FULL;
                            end else if (status.empty) begin
                                cmd.front_wr = 1'b1;
                            end else if (status.odd) begin
                                cmd.back_wr_tail = 1'b1;
                            end else begin
                                // Front half falls one short: pull the back head over.
                                cmd.back_wr_tail = 1'b1;
                                cmd.back_rd      = 1'b1;
                                move_next        = 1'b1;
                            end
                        end
                        qmi_pkg::OP_INSERT: begin
                            if (status.full) begin
                                res_next   = 1'b1;
                                rstat_next = qmi_pkg::STAT_FULL;
                            end else if (status.odd) begin
                                cmd.back_wr_head = 1'b1;
                            end else begin
                                cmd.front_wr = 1'b1;
                            end
                        end
                        qmi_pkg::OP_POP: begin
                            res_next = 1'b1;
                            if (status.empty) begin
                                rstat_next = qmi_pkg::STAT_EMPTY;
                            end else begin
                                cmd.front_rd = 1'b1;
                                pop_next     = 1'b1;
                                if (!status.odd) begin
                                    cmd.back_rd = 1'b1;
                                    move_next   = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    cmd.fin_move = move_reg;
                    cmd.fin_load = res_reg;
                    cmd.fin_pop  = pop_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.fin_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            res_reg    <= 1'b0;
            pop_reg    <= 1'b0;
            move_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            res_reg    <= res_next;
            pop_reg    <= pop_next;
            move_reg   <= move_next;
        end
    end

    always_ff @(posedge aclk) begin
        rstat_reg <= rstat_next;
        if (cmd.fin_load) begin
            mstat_reg <= rstat_reg;
        end
    end

endmodule

`default_nettype wire

// ----- sv/qmi_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qmi_dp #(
    parameter int DEPTH = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire qmi_pkg::qmi_cmd_t    cmd,
    input  wire logic [31:0]          s_value,
    output qmi_pkg::qmi_status_t      status,
    output logic [31:0]               m_value
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] fh_reg, fh_next;    // front-half head slot
    logic [AW-1:0] ft_reg, ft_next;    // front-half next free slot
    logic [AW-1:0] bh_reg, bh_next;    // back-half head slot
    logic [AW-1:0] bt_reg, bt_next;    // back-half next free slot
    logic [AW-1:0] move_addr_reg;
    logic [31:0]   data_reg;

    logic          f_we, b_we;
    logic [AW-1:0] f_waddr, b_waddr;
    logic [31:0]   f_wdata;
    logic [31:0]   f_rdata, b_rdata;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.odd   = cnt_reg[0];
    assign m_value      = data_reg;

    always_comb begin
        cnt_next = cnt_reg;
        fh_next  = fh_reg;
        ft_next  = ft_reg;
        bh_next  = bh_reg;
        bt_next  = bt_reg;
        if (cmd.front_wr || cmd.back_wr_tail || cmd.back_wr_head) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (cmd.front_rd) begin
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.front_wr || cmd.back_rd) begin
            ft_next = slot_inc(ft_reg);
        end
        if (cmd.front_rd) begin
            fh_next = slot_inc(fh_reg);
        end
        if (cmd.back_wr_tail) begin
            bt_next = slot_inc(bt_reg);
        end
        if (cmd.back_rd) begin
            bh_next = slot_inc(bh_reg);
        end else if (cmd.back_wr_head) begin
            bh_next = slot_dec(bh_reg);
        end
    end

    // Front-half writes come either straight from a request or from a move.
    always_comb begin
        f_we    = cmd.front_wr || cmd.fin_move;
        f_waddr = cmd.front_wr ? ft_reg : move_addr_reg;
        f_wdata = cmd.front_wr ? s_value : b_rdata;
        b_we    = cmd.back_wr_tail || cmd.back_wr_head;
        b_waddr = cmd.back_wr_tail ? bt_reg : slot_dec(bh_reg);
    end

    qmi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_front_ram (
        .clk   (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (cmd.front_rd),
        .raddr (fh_reg),
        .rdata (f_rdata)
    );

    qmi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_back_ram (
        .clk   (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (s_value),
        .re    (cmd.back_rd),
        .raddr (bh_reg),
        .rdata (b_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            fh_reg  <= '0;
            ft_reg  <= '0;
            bh_reg  <= '0;
            bt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            fh_reg  <= fh_next;
            ft_reg  <= ft_next;
            bh_reg  <= bh_next;
            bt_reg  <= bt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.back_rd) begin
            move_addr_reg <= ft_reg;
        end
        if (cmd.fin_load) begin
            data_reg <= cmd.fin_pop ? f_rdata : 32'd0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/queue_with_middle_insert.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bounded queue of signed 32-bit values, up to DEPTH entries, that accepts three
// requests on s_tuser: push at the tail, insert at position ceil(n/2) from the
// head (n is the count before the insert), and pop from the head. A pop returns
// the head value with status ok, or zero with status empty when the queue has no
// entries; a push or insert on a full queue returns zero with status full. An
// accepted push or insert returns nothing, and the unused request code is
// dropped. Each request is accepted in the idle state, which issues the memory
// reads and writes, and completes in the finishing state, which finishes the
// rebalancing move from the registered RAM read and loads the result register.
// A request waits before completing only while it has a result and the
// previous one has not yet been taken. The queue lives in two ring buffers, one
// per half, so every request touches at most one entry plus one move; no
// clearing pass is needed after reset.
module queue_with_middle_insert #(
    parameter int DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] popped_value
    output logic [1:0]       m_tuser    // [1:0] status
);

    qmi_pkg::qmi_cmd_t    ctrl_cmd;
    qmi_pkg::qmi_status_t dp_status;

    // The controller sequences each request and owns the handshakes.
    qmi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (m_tuser),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    // The datapath holds the two half-queues, their pointers and the count.
    qmi_dp #(.DEPTH(DEPTH)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ctrl_cmd),
        .s_value (s_tdata),
        .status  (dp_status),
        .m_value (m_tdata)
    );

    // After a transfer in, the input is not ready again until the request completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // Loading a result always presents it on the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.fin_load |=> m_tvalid)
        else $error("loaded result not presented");

    // Only a successful pop carries a nonzero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != qmi_pkg::STAT_OK) |-> (m_tdata == 32'd0))
        else $error("nonzero value with error status");

    // The queue never reports itself both empty and full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(dp_status.empty && dp_status.full))
        else $error("queue empty and full at once");

endmodule

`default_nettype wire

// ----- verif/queue_with_middle_insert_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the middle-insert queue. Requests are generated up
// front into a pending queue; a clocked driver sends them in bursts separated
// by random gaps, and a clocked monitor takes results through a receiver that
// switches at random between stall behaviors. Every accepted request is
// applied to a behavioral image of the queue, and any result it should
// produce is stored in order and compared field by field with what comes out.
module queue_with_middle_insert_tb;

    localparam int DEPTH = 1024;

    // The fourth request code has no meaning and must be dropped silently.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Generous bound on the run length. The slowest legal run is roughly
    // 1800 transfers, each adding sender gap, block handling and receiver stall.
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] value;
    } request_t;

    typedef struct packed {
        logic [31:0] popped_value;
        logic [1:0]  status;
    } result_t;

    // Receiver behaviors; each one holds for a random stretch of cycles.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    // Requests waiting for the driver, the behavioral queue contents, and the
    // results that the block still owes us, oldest first.
    request_t         pending_requests[$];
    logic signed [31:0] queue_image[$];
    result_t          expected_results[$];

    int unsigned cycle_count     = 0;
    int unsigned accepted_count  = 0;
    int unsigned result_count    = 0;
    int unsigned full_rejects    = 0;
    int unsigned empty_pops      = 0;
    int unsigned mismatch_count  = 0;
    int unsigned peak_occupancy  = 0;

    // Generator-side occupancy, used only to steer the request mix.
    int unsigned gen_count = 0;

    queue_with_middle_insert #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [31:0] value
        .s_tuser (s_tuser),   // [1:0] opcode
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [31:0] popped_value
        .m_tuser (m_tuser)    // [1:0] status
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one accepted request to the queue image. A pop always answers;
    // an enqueue answers only when it is turned away because the queue is full.
    function automatic void apply_request(request_t req);
        result_t     res;
        int unsigned mid_pos;
        res = '0;
        case (req.opcode)
            qmi_pkg::OP_PUSH, qmi_pkg::OP_INSERT: begin
                if (queue_image.size() >= DEPTH) begin
                    res.status = qmi_pkg::STAT_FULL;
                    expected_results.push_back(res);
                end else if (req.opcode == qmi_pkg::OP_PUSH) begin
                    queue_image.push_back(req.value);
                end else begin
                    // The new entry lands at position ceil(n/2) from the head.
                    mid_pos = (queue_image.size() + 1) / 2;
                    queue_image.insert(mid_pos, req.value);
                end
                if (queue_image.size() > peak_occupancy)
                    peak_occupancy = queue_image.size();
            end
            qmi_pkg::OP_POP: begin
                if (queue_image.size() == 0) begin
                    res.status = qmi_pkg::STAT_EMPTY;
                end else begin
                    res.popped_value = queue_image.pop_front();
                    res.status       = qmi_pkg::STAT_OK;
                end
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Queue one request for the driver and track the occupancy it leads to.
    task automatic add_request(logic [1:0] opcode, logic [31:0] value);
        request_t req;
        req.opcode = opcode;
        req.value  = value;
        pending_requests.push_back(req);
        if ((opcode == qmi_pkg::OP_PUSH || opcode == qmi_pkg::OP_INSERT) && gen_count < DEPTH)
            gen_count++;
        else if (opcode == qmi_pkg::OP_POP && gen_count > 0)
            gen_count--;
    endtask

    // Mostly random data, with the sign and magnitude extremes mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Draw a request code from weights given in percent for push, insert
    // and pop; whatever is left over goes to the unused code.
    function automatic logic [1:0] pick_opcode(int push_pct, int insert_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return qmi_pkg::OP_PUSH;
        if (roll < push_pct + insert_pct)
            return qmi_pkg::OP_INSERT;
        if (roll < push_pct + insert_pct + pop_pct)
            return qmi_pkg::OP_POP;
        return OP_UNUSED;
    endfunction

    // Sender: bursts of random length, each followed by a random gap. Gaps
    // are often zero so that long back-to-back stretches occur as well.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    request_t    driven_req = '0;

    always @(posedge aclk) begin : sender
        logic     accepted;
        logic     next_valid;
        request_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            accepted   = s_tvalid && s_tready;
            next_valid = 1'b0;
            if (accepted) begin
                apply_request(driven_req);
                accepted_count++;
            end
            if (s_tvalid && !accepted) begin
                // The offered transfer must stay put until it is taken.
                next_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() > 0) begin
                next_req   = pending_requests.pop_front();
                driven_req = next_req;
                next_valid = 1'b1;
                s_tdata   <= next_req.value;
                s_tuser   <= next_req.opcode;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: switches between always ready, coin-flip ready, a fixed
    // three-of-five pattern, and mostly stalled.
    rx_mode_t    rx_mode      = RX_ALWAYS;
    int unsigned rx_mode_left = 0;

    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(32, 200);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_ALWAYS:  m_tready <= 1'b1;
            RX_RANDOM:  m_tready <= $urandom_range(0, 1);
            RX_PATTERN: m_tready <= (cycle_count % 5) < 3;
            default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Monitor: every result transfer is matched against the oldest expectation.
    always @(posedge aclk) begin : monitor
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: popped_value=%0d status=%0d",
                             $realtime, $signed(m_tdata), m_tuser);
            end else begin
                want = expected_results.pop_front();
                if (want.status == qmi_pkg::STAT_FULL)
                    full_rejects++;
                else if (want.status == qmi_pkg::STAT_EMPTY)
                    empty_pops++;
                if (m_tdata !== want.popped_value) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] popped_value mismatch: expected %0d, got %0d",
                                 $realtime, $signed(want.popped_value), $signed(m_tdata));
                end
                if (m_tuser !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] status mismatch: expected %0d, got %0d",
                                 $realtime, want.status, m_tuser);
                end
            end
        end
    end

    // Watchdog on the total cycle count.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int n;

        // Directed opening: empty-queue pop, the dropped code, an insert into
        // an empty queue, inserts at both odd and even counts, the value
        // extremes, and a drain that ends with one more pop on empty.
        add_request(qmi_pkg::OP_POP,    32'h1234_5678);
        add_request(OP_UNUSED,          32'hdead_beef);
        add_request(qmi_pkg::OP_INSERT, 32'h7fff_ffff);
        add_request(qmi_pkg::OP_PUSH,   32'h8000_0000);
        add_request(qmi_pkg::OP_INSERT, 32'h0000_0000);
        add_request(qmi_pkg::OP_PUSH,   32'hffff_ffff);
        add_request(qmi_pkg::OP_INSERT, 32'h0000_0001);
        add_request(qmi_pkg::OP_INSERT, 32'haaaa_aaaa);
        add_request(qmi_pkg::OP_PUSH,   32'h5555_5555);
        add_request(OP_UNUSED,          32'hffff_ffff);
        for (n = 0; n < 8; n++)
            add_request(qmi_pkg::OP_POP, 32'hffff_ffff);
        add_request(qmi_pkg::OP_INSERT, 32'h8000_0000);
        add_request(qmi_pkg::OP_POP,    32'h0000_0000);

        // Churn at low occupancy so the queue keeps running empty.
        for (n = 0; n < 250; n++)
            add_request(pick_opcode(30, 30, 37), pick_value());

        // Grow until full; the pops along the way move the head around the
        // ring so that the full queue wraps.
        while (gen_count < DEPTH)
            add_request(pick_opcode(45, 40, 12), pick_value());

        // Work at the full boundary: most enqueues are turned away, and the
        // ones that follow a pop refill the freed slot.
        for (n = 0; n < 60; n++)
            add_request(pick_opcode(40, 35, 23), pick_value());

        // Partial drain with inserts still landing mid-queue.
        for (n = 0; n < 150; n++)
            add_request(pick_opcode(15, 25, 58), pick_value());

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        // A trailing request without a result may still be in the block.
        repeat (8) @(posedge aclk);

        $display("%0d requests accepted, %0d results checked (%0d full rejects, %0d empty pops)",
                 accepted_count, result_count, full_rejects, empty_pops);
        $display("peak occupancy %0d of %0d entries, %0d mismatches, %0d cycles",
                 peak_occupancy, DEPTH, mismatch_count, cycle_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/qmi_pkg.sv
sv/qmi_ram.sv
sv/qmi_ctrl.sv
sv/qmi_dp.sv
sv/queue_with_middle_insert.sv
verif/queue_with_middle_insert_tb.sv
